// ----- design/rbi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbi_pkg
// Shared types, codes and fixed-point helpers of the rigid-body integrator.
// ----------------------------------------------------------------------------
package rbi_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_DRAG_COEF       = 3'd0;
    localparam logic [2:0] CFG_GRAVITY_ACCEL   = 3'd1;
    localparam logic [2:0] CFG_USE_RK4         = 3'd2;
    localparam logic [2:0] CFG_SPEED_LIMIT     = 3'd3;
    localparam logic [2:0] CFG_LIMIT_ENABLED   = 3'd4;
    localparam logic [2:0] CFG_PHYSICS_ENABLED = 3'd5;
    localparam logic [2:0] CFG_SIMULATED       = 3'd6;

    // item kinds
    localparam logic OP_STEP    = 1'b0;
    localparam logic OP_IMPULSE = 1'b1;

    localparam logic [30:0] SPEED_LIMIT_RESET = 31'd163840000;

    // reciprocal of three scaled by 2^33, exact for 32-bit dividends
    localparam logic [31:0] RECIP3 = 32'haaaaaaab;

    // sequencer states
    typedef enum logic [24:0] {
        S_IDLE      = 25'h0000001,
        S_ACC_MUL   = 25'h0000002,
        S_ACC_USE   = 25'h0000004,
        S_DX_MUL    = 25'h0000008,
        S_DX_USE    = 25'h0000010,
        S_EU_VMUL   = 25'h0000020,
        S_EU_VUSE   = 25'h0000040,
        S_EU_PMUL   = 25'h0000080,
        S_EU_PUSE   = 25'h0000100,
        S_FIN_DIV   = 25'h0000200,
        S_DIV_RUN   = 25'h0000400,
        S_DIV_DONE  = 25'h0000800,
        S_FIN_MUL   = 25'h0001000,
        S_FIN_USE   = 25'h0002000,
        S_IMP_ADD   = 25'h0004000,
        S_SQ_MUL    = 25'h0008000,
        S_SQ_USE    = 25'h0010000,
        S_LIM_MUL   = 25'h0020000,
        S_LIM_USE   = 25'h0040000,
        S_SQRT_RUN  = 25'h0080000,
        S_SQRT_DONE = 25'h0100000,
        S_CL_MUL    = 25'h0200000,
        S_CL_DIV    = 25'h0400000,
        S_OUT       = 25'h0800000,
        S_FIN_Q     = 25'h1000000
    } state_t;

    // sign extend a Q16.16 word to product width
    function automatic logic signed [65:0] ext66(input logic signed [31:0] a);
        ext66 = {{34{a[31]}}, a};
    endfunction

    // sign extend a Q16.16 word to accumulator width
    function automatic logic signed [34:0] ext35(input logic signed [31:0] a);
        ext35 = {{3{a[31]}}, a};
    endfunction

    // sign extend a Q16.16 word to multiplier operand width
    function automatic logic signed [32:0] ext33(input logic signed [31:0] a);
        ext33 = {a[31], a};
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat_q(input logic signed [65:0] x);
        if (x > 66'sd2147483647) begin
            sat_q = 32'sh7fffffff;
        end else if (x < -66'sd2147483648) begin
            sat_q = 32'sh80000000;
        end else begin
            sat_q = x[31:0];
        end
    endfunction

endpackage

// ----- design/rigid_body_rk4_integrator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rigid_body_rk4_integrator_core
// One body's position and velocity, advanced by RK4 or semi-implicit Euler
// steps and changed by impulses with an optional speed clamp.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one item per transfer: s_tuser[0] is the kind (0 step,
//   1 impulse), s_tdata the time step and impulse vector. m_* returns the
//   whole body state after each item. cfg_* writes the configuration
//   registers; it is always ready, and the user must write it only between
//   items, which the block does not enforce. All arithmetic runs through
//   one registered 33x33 multiplier (which also divides by six through a
//   reciprocal), one restoring divider (one quotient bit per cycle) and one
//   bit-pair square root unit under a sequencer, so the block takes one item
//   at a time. A step with the body or physics off, or an impulse with the
//   body off, returns the held state. A clamped impulse also takes a square
//   root and three divides, one per component.
//   s_tready is low from an input transfer until the result transfer.
//   A stalled m_tready holds the result and the block waits.
//   Reset sets the state to zero and the registers to their defaults.
// ----------------------------------------------------------------------------
module rigid_body_rk4_integrator_core (
    input  logic         aclk,
    input  logic         aresetn,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [119:0] s_tdata,   // step_dt, impulse_x, impulse_y, impulse_z
    input  logic [0:0]   s_tuser,   // opcode
    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,   // out_pos_x/y/z, out_vel_x/y/z
    // configuration writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    // configuration registers
    logic [30:0]        drag_coef_reg;
    logic signed [31:0] gravity_accel_reg;
    logic               use_rk4_reg;
    logic [30:0]        speed_limit_reg;
    logic               limit_enabled_reg;
    logic               physics_enabled_reg;
    logic               simulated_reg;

    // body state and working registers
    rbi_pkg::state_t    state_reg, state_next;
    logic signed [31:0] p_reg  [3];
    logic signed [31:0] p_next [3];
    logic signed [31:0] v_reg  [3];
    logic signed [31:0] v_next [3];
    logic signed [31:0] ev_reg  [3];
    logic signed [31:0] ev_next [3];
    logic signed [31:0] dv_reg  [3];
    logic signed [31:0] dv_next [3];
    logic signed [34:0] sx_reg  [3];
    logic signed [34:0] sx_next [3];
    logic signed [34:0] sv_reg  [3];
    logic signed [34:0] sv_next [3];
    logic [1:0]         idx_reg, idx_next;
    logic [1:0]         stg_reg, stg_next;
    logic               fin_v_reg, fin_v_next;
    logic [19:0]        dt_reg, dt_next;
    logic signed [31:0] imp_reg  [3];
    logic signed [31:0] q_reg, q_next;
    logic [63:0]        mag2_reg, mag2_next;
    logic [31:0]        mag_reg, mag_next;
    logic [4:0]         cnt_reg, cnt_next;

    // divider and square root registers
    logic [31:0]        div_rem_reg, div_rem_next;
    logic [31:0]        div_lo_reg, div_lo_next;
    logic [31:0]        div_dvs_reg, div_dvs_next;
    logic [63:0]        sq_n_reg, sq_n_next;
    logic [63:0]        sq_r_reg, sq_r_next;
    logic [63:0]        sq_bit_reg, sq_bit_next;

    // shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_reg;
    logic signed [65:0] prod_next;

    // handshakes
    assign s_tready  = (state_reg == rbi_pkg::S_IDLE);
    assign m_tvalid  = (state_reg == rbi_pkg::S_OUT);
    assign cfg_ready = 1'b1;
    assign m_tdata   = {v_reg[2], v_reg[1], v_reg[0], p_reg[2], p_reg[1], p_reg[0]};

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drag_coef_reg       <= '0;
            gravity_accel_reg   <= '0;
            use_rk4_reg         <= 1'b0;
            speed_limit_reg     <= rbi_pkg::SPEED_LIMIT_RESET;
            limit_enabled_reg   <= 1'b1;
            physics_enabled_reg <= 1'b1;
            simulated_reg       <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                rbi_pkg::CFG_DRAG_COEF:       drag_coef_reg       <= cfg_data[30:0];
                rbi_pkg::CFG_GRAVITY_ACCEL:   gravity_accel_reg   <= cfg_data;
                rbi_pkg::CFG_USE_RK4:         use_rk4_reg         <= cfg_data[0];
                rbi_pkg::CFG_SPEED_LIMIT:     speed_limit_reg     <= cfg_data[30:0];
                rbi_pkg::CFG_LIMIT_ENABLED:   limit_enabled_reg   <= cfg_data[0];
                rbi_pkg::CFG_PHYSICS_ENABLED: physics_enabled_reg <= cfg_data[0];
                rbi_pkg::CFG_SIMULATED:       simulated_reg       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // helper values
    logic signed [32:0] v_abs;
    logic [19:0]        h_sel;
    logic signed [31:0] prod_q;
    logic signed [31:0] g_neg;
    logic               w2;
    logic signed [34:0] s_sel;
    logic [34:0]        s_mag;
    logic [32:0]        div_shift;
    logic               div_ge;
    logic [32:0]        div_diff;
    logic [63:0]        sq_t;
    logic signed [32:0] quo_neg;
    logic [31:0]        d6_y;
    logic [31:0]        d6_t;
    logic [31:0]        d6_r;
    logic               d6_up;
    logic [31:0]        d6_q;

    assign v_abs   = v_reg[idx_reg][31] ? -rbi_pkg::ext33(v_reg[idx_reg])
                                        :  rbi_pkg::ext33(v_reg[idx_reg]);
    assign h_sel   = (stg_reg == 2'd3) ? dt_reg : {1'b0, dt_reg[19:1]};
    assign prod_q  = rbi_pkg::sat_q(prod_reg >>> 16);
    assign g_neg   = rbi_pkg::sat_q(-rbi_pkg::ext66(gravity_accel_reg));
    assign w2      = (stg_reg == 2'd1) || (stg_reg == 2'd2);
    assign s_sel   = fin_v_reg ? sv_reg[idx_reg] : sx_reg[idx_reg];
    assign s_mag   = s_sel[34] ? 35'(-s_sel + 35'sd5) : s_sel;
    assign div_shift = {div_rem_reg, div_lo_reg[31]};
    assign div_ge    = (div_shift >= {1'b0, div_dvs_reg});
    assign div_diff  = div_shift - {1'b0, div_dvs_reg};
    assign sq_t      = sq_r_reg + sq_bit_reg;
    assign quo_neg   = -$signed({1'b0, div_lo_reg});

    // divide by six: floor(x / 4) / 3 by reciprocal, then fold in bit 1 of x
    assign d6_y  = s_mag[33:2];
    assign d6_t  = {1'b0, prod_reg[63:33]};
    assign d6_r  = d6_y - ((d6_t << 1) + d6_t);
    assign d6_up = ({d6_r[1:0], s_mag[1]} >= 3'd3);
    assign d6_q  = {d6_t[30:0], 1'b0} + {31'd0, d6_up};

    // multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            rbi_pkg::S_ACC_MUL: begin
                mul_a = -rbi_pkg::ext33(ev_reg[0]);
                mul_b = $signed({2'b00, drag_coef_reg});
            end
            rbi_pkg::S_DX_MUL: begin
                mul_a = rbi_pkg::ext33(dv_reg[idx_reg]);
                mul_b = $signed({13'd0, h_sel});
            end
            rbi_pkg::S_EU_VMUL: begin
                mul_a = rbi_pkg::ext33(dv_reg[idx_reg]);
                mul_b = $signed({13'd0, dt_reg});
            end
            rbi_pkg::S_EU_PMUL: begin
                mul_a = rbi_pkg::ext33(v_reg[idx_reg]);
                mul_b = $signed({13'd0, dt_reg});
            end
            rbi_pkg::S_FIN_DIV: begin
                mul_a = $signed({1'b0, d6_y});
                mul_b = $signed({1'b0, rbi_pkg::RECIP3});
            end
            rbi_pkg::S_FIN_MUL: begin
                mul_a = rbi_pkg::ext33(q_reg);
                mul_b = $signed({13'd0, dt_reg});
            end
            rbi_pkg::S_SQ_MUL: begin
                mul_a = v_abs;
                mul_b = v_abs;
            end
            rbi_pkg::S_LIM_MUL: begin
                mul_a = $signed({2'b00, speed_limit_reg});
                mul_b = $signed({2'b00, speed_limit_reg});
            end
            rbi_pkg::S_CL_MUL: begin
                mul_a = v_abs;
                mul_b = $signed({2'b00, speed_limit_reg});
            end
            default: ;
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // sequencer
    always_comb begin
        state_next     = state_reg;
        p_next         = p_reg;
        v_next         = v_reg;
        ev_next        = ev_reg;
        dv_next        = dv_reg;
        sx_next        = sx_reg;
        sv_next        = sv_reg;
        idx_next       = idx_reg;
        stg_next       = stg_reg;
        fin_v_next     = fin_v_reg;
        dt_next        = dt_reg;
        q_next         = q_reg;
        mag2_next      = mag2_reg;
        mag_next       = mag_reg;
        cnt_next       = cnt_reg;
        div_rem_next   = div_rem_reg;
        div_lo_next    = div_lo_reg;
        div_dvs_next   = div_dvs_reg;
        sq_n_next      = sq_n_reg;
        sq_r_next      = sq_r_reg;
        sq_bit_next    = sq_bit_reg;

        case (state_reg)
            rbi_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    dt_next  = s_tdata[19:0];
                    idx_next = 2'd0;
                    if (s_tuser[0] == rbi_pkg::OP_STEP) begin
                        if (physics_enabled_reg && simulated_reg) begin
                            ev_next    = v_reg;
                            sx_next    = '{default: '0};
                            sv_next    = '{default: '0};
                            stg_next   = 2'd0;
                            fin_v_next = 1'b0;
                            state_next = rbi_pkg::S_ACC_MUL;
                        end else begin
                            state_next = rbi_pkg::S_OUT;
                        end
                    end else begin
                        state_next = simulated_reg ? rbi_pkg::S_IMP_ADD : rbi_pkg::S_OUT;
                    end
                end
            end

            // acceleration of the evaluated velocity, weighted into the sums
            rbi_pkg::S_ACC_MUL: state_next = rbi_pkg::S_ACC_USE;
            rbi_pkg::S_ACC_USE: begin
                dv_next[0] = prod_q;
                dv_next[1] = g_neg;
                dv_next[2] = '0;
                for (int i = 0; i < 3; i++) begin
                    sx_next[i] = sx_reg[i] + (w2 ? (rbi_pkg::ext35(ev_reg[i]) <<< 1)
                                                 :  rbi_pkg::ext35(ev_reg[i]));
                end
                sv_next[0] = sv_reg[0] + (w2 ? (rbi_pkg::ext35(prod_q) <<< 1)
                                             :  rbi_pkg::ext35(prod_q));
                sv_next[1] = sv_reg[1] + (w2 ? (rbi_pkg::ext35(g_neg) <<< 1)
                                             :  rbi_pkg::ext35(g_neg));
                idx_next = 2'd0;
                if (!use_rk4_reg) begin
                    state_next = rbi_pkg::S_EU_VMUL;
                end else if (stg_reg == 2'd3) begin
                    state_next = rbi_pkg::S_FIN_DIV;
                end else begin
                    stg_next   = stg_reg + 2'd1;
                    state_next = rbi_pkg::S_DX_MUL;
                end
            end

            // next evaluation point v + dv * h
            rbi_pkg::S_DX_MUL: state_next = rbi_pkg::S_DX_USE;
            rbi_pkg::S_DX_USE: begin
                ev_next[idx_reg] = rbi_pkg::sat_q(rbi_pkg::ext66(v_reg[idx_reg])
                                                  + rbi_pkg::ext66(prod_q));
                if (idx_reg == 2'd2) begin
                    state_next = rbi_pkg::S_ACC_MUL;
                end else begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = rbi_pkg::S_DX_MUL;
                end
            end

            // semi-implicit euler: velocity first, then position
            rbi_pkg::S_EU_VMUL: state_next = rbi_pkg::S_EU_VUSE;
            rbi_pkg::S_EU_VUSE: begin
                v_next[idx_reg] = rbi_pkg::sat_q(rbi_pkg::ext66(v_reg[idx_reg])
                                                 + rbi_pkg::ext66(prod_q));
                state_next = rbi_pkg::S_EU_PMUL;
            end
            rbi_pkg::S_EU_PMUL: state_next = rbi_pkg::S_EU_PUSE;
            rbi_pkg::S_EU_PUSE: begin
                p_next[idx_reg] = rbi_pkg::sat_q(rbi_pkg::ext66(p_reg[idx_reg])
                                                 + rbi_pkg::ext66(prod_q));
                if (idx_reg == 2'd2) begin
                    state_next = rbi_pkg::S_OUT;
                end else begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = rbi_pkg::S_EU_VMUL;
                end
            end

            // floor divide of a weighted sum by six, reciprocal product first
            rbi_pkg::S_FIN_DIV: state_next = rbi_pkg::S_FIN_Q;
            rbi_pkg::S_FIN_Q: begin
                q_next     = s_sel[34] ? 32'(-d6_q) : d6_q;
                state_next = rbi_pkg::S_FIN_MUL;
            end

            // one quotient bit per cycle
            rbi_pkg::S_DIV_RUN: begin
                div_rem_next = div_ge ? div_diff[31:0] : div_shift[31:0];
                div_lo_next  = {div_lo_reg[30:0], div_ge};
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    state_next = rbi_pkg::S_DIV_DONE;
                end
            end
            rbi_pkg::S_DIV_DONE: begin
                v_next[idx_reg] = v_reg[idx_reg][31] ? quo_neg[31:0] : div_lo_reg;
                if (idx_reg == 2'd2) begin
                    state_next = rbi_pkg::S_OUT;
                end else begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = rbi_pkg::S_CL_MUL;
                end
            end

            // state update by the averaged slope times dt
            rbi_pkg::S_FIN_MUL: state_next = rbi_pkg::S_FIN_USE;
            rbi_pkg::S_FIN_USE: begin
                if (!fin_v_reg) begin
                    p_next[idx_reg] = rbi_pkg::sat_q(rbi_pkg::ext66(p_reg[idx_reg])
                                                     + rbi_pkg::ext66(prod_q));
                    fin_v_next = 1'b1;
                    state_next = rbi_pkg::S_FIN_DIV;
                end else begin
                    v_next[idx_reg] = rbi_pkg::sat_q(rbi_pkg::ext66(v_reg[idx_reg])
                                                     + rbi_pkg::ext66(prod_q));
                    fin_v_next = 1'b0;
                    if (idx_reg == 2'd2) begin
                        state_next = rbi_pkg::S_OUT;
                    end else begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = rbi_pkg::S_FIN_DIV;
                    end
                end
            end

            // impulse: add, then squared speed
            rbi_pkg::S_IMP_ADD: begin
                for (int i = 0; i < 3; i++) begin
                    v_next[i] = rbi_pkg::sat_q(rbi_pkg::ext66(v_reg[i])
                                               + rbi_pkg::ext66(imp_reg[i]));
                end
                mag2_next  = '0;
                state_next = rbi_pkg::S_SQ_MUL;
            end
            rbi_pkg::S_SQ_MUL: state_next = rbi_pkg::S_SQ_USE;
            rbi_pkg::S_SQ_USE: begin
                mag2_next = mag2_reg + prod_reg[63:0];
                if (idx_reg == 2'd2) begin
                    state_next = rbi_pkg::S_LIM_MUL;
                end else begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = rbi_pkg::S_SQ_MUL;
                end
            end
            rbi_pkg::S_LIM_MUL: state_next = rbi_pkg::S_LIM_USE;
            rbi_pkg::S_LIM_USE: begin
                if (limit_enabled_reg && (mag2_reg > prod_reg[63:0])) begin
                    sq_n_next   = mag2_reg;
                    sq_r_next   = '0;
                    sq_bit_next = 64'h4000_0000_0000_0000;
                    cnt_next    = '0;
                    state_next  = rbi_pkg::S_SQRT_RUN;
                end else begin
                    state_next = rbi_pkg::S_OUT;
                end
            end

            // integer square root, one result bit per cycle
            rbi_pkg::S_SQRT_RUN: begin
                if (sq_n_reg >= sq_t) begin
                    sq_n_next = sq_n_reg - sq_t;
                    sq_r_next = (sq_r_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_r_next = sq_r_reg >> 1;
                end
                sq_bit_next = sq_bit_reg >> 2;
                cnt_next    = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    state_next = rbi_pkg::S_SQRT_DONE;
                end
            end
            rbi_pkg::S_SQRT_DONE: begin
                mag_next   = (sq_r_reg[31:0] == 32'd0) ? 32'd1 : sq_r_reg[31:0];
                idx_next   = 2'd0;
                state_next = rbi_pkg::S_CL_MUL;
            end

            // scale each component: |v| * limit / magnitude
            rbi_pkg::S_CL_MUL: state_next = rbi_pkg::S_CL_DIV;
            rbi_pkg::S_CL_DIV: begin
                div_rem_next   = prod_reg[63:32];
                div_lo_next    = prod_reg[31:0];
                div_dvs_next   = mag_reg;
                cnt_next       = '0;
                state_next     = rbi_pkg::S_DIV_RUN;
            end

            // result waits for the receiver
            rbi_pkg::S_OUT: begin
                if (m_tready) begin
                    state_next = rbi_pkg::S_IDLE;
                end
            end

            default: state_next = rbi_pkg::S_IDLE;
        endcase
    end

    // control and body state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rbi_pkg::S_IDLE;
            p_reg     <= '{default: '0};
            v_reg     <= '{default: '0};
        end else begin
            state_reg <= state_next;
            p_reg     <= p_next;
            v_reg     <= v_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        ev_reg        <= ev_next;
        dv_reg        <= dv_next;
        sx_reg        <= sx_next;
        sv_reg        <= sv_next;
        idx_reg       <= idx_next;
        stg_reg       <= stg_next;
        fin_v_reg     <= fin_v_next;
        dt_reg        <= dt_next;
        q_reg         <= q_next;
        mag2_reg      <= mag2_next;
        mag_reg       <= mag_next;
        cnt_reg       <= cnt_next;
        div_rem_reg   <= div_rem_next;
        div_lo_reg    <= div_lo_next;
        div_dvs_reg   <= div_dvs_next;
        sq_n_reg      <= sq_n_next;
        sq_r_reg      <= sq_r_next;
        sq_bit_reg    <= sq_bit_next;
        prod_reg      <= prod_next;
        if (s_tvalid && s_tready) begin
            imp_reg[0] <= s_tdata[51:20];
            imp_reg[1] <= s_tdata[83:52];
            imp_reg[2] <= s_tdata[115:84];
        end
    end

endmodule

// ----- design/rbi_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbi_checker
// Port-level checks of the integrator's item and result channels.
// ----------------------------------------------------------------------------
module rbi_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [191:0] m_tdata
);

    // one item in flight: never ready while a result is offered
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    // an accepted item closes the input side on the next cycle
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input still ready after a transfer");

    // a result is not offered again after its transfer
    a_single_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> !m_tvalid)
        else $error("result repeated");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind rigid_body_rk4_integrator_core rbi_checker u_rbi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- test/tb_rigid_body_rk4_integrator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rigid_body_rk4_integrator_core
// Drives step and impulse items through the rigid-body integrator under
// several register settings and idle patterns. Every result is checked
// against a fixed-point model of the body state kept in the testbench.
// ----------------------------------------------------------------------------
module tb_rigid_body_rk4_integrator_core;

    localparam longint Q_HI = 64'sd2147483647;
    localparam longint Q_LO = -64'sd2147483648;

    // ------------------------------------------------------------------------
    // body state model and store of expected states
    // ------------------------------------------------------------------------
    class body_scoreboard;
        longint drag, grav, lim;
        bit     rk4, lim_en, phys_en, sim_en;
        longint pos[3], vel[3];
        logic [191:0] pending_states[$];
        int     errors;

        function new();
            drag = 0; grav = 0; rk4 = 0; lim = 163840000;
            lim_en = 1; phys_en = 1; sim_en = 1;
            for (int i = 0; i < 3; i++) begin
                pos[i] = 0; vel[i] = 0;
            end
            errors = 0;
        endfunction

        function longint sat(longint v);
            return v > Q_HI ? Q_HI : (v < Q_LO ? Q_LO : v);
        endfunction

        // product shift with rounding toward minus infinity
        function longint shr_floor(longint p);
            return p >>> 16;
        endfunction

        function longint fmul(longint a, longint b);
            return sat(shr_floor(a * b));
        endfunction

        function longint div6_floor(longint s);
            longint q;
            q = s / 6;
            if (s % 6 != 0 && s < 0) q--;
            return q;
        endfunction

        function void accel(input longint v[3], output longint a[3]);
            a[0] = sat(shr_floor((-v[0]) * drag));
            a[1] = sat(-grav);
            a[2] = 0;
        endfunction

        function void stage_eval(input longint v[3], input longint h, input longint dvin[3],
                                 output longint dx[3], output longint dv[3]);
            for (int i = 0; i < 3; i++) dx[i] = sat(v[i] + fmul(dvin[i], h));
            accel(dx, dv);
        endfunction

        function longint isqrt(longint unsigned n);
            longint unsigned r, b;
            r = 0; b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n -= r + b; r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] d);
            case (idx)
                rbi_pkg::CFG_DRAG_COEF:       drag = d[30:0];
                rbi_pkg::CFG_GRAVITY_ACCEL:   grav = longint'($signed(d));
                rbi_pkg::CFG_USE_RK4:         rk4 = d[0];
                rbi_pkg::CFG_SPEED_LIMIT:     lim = d[30:0];
                rbi_pkg::CFG_LIMIT_ENABLED:   lim_en = d[0];
                rbi_pkg::CFG_PHYSICS_ENABLED: phys_en = d[0];
                rbi_pkg::CFG_SIMULATED:       sim_en = d[0];
                default: ;
            endcase
        endfunction

        // note an accepted input item and queue the state it leads to
        function void note_item(logic op, logic [119:0] d);
            longint dt, h2, sx, sv;
            longint a[3], bdx[3], bdv[3], cdx[3], cdv[3], ddx[3], ddv[3];
            longint unsigned m[3], mag2, lim2, mag;
            logic [191:0] st;
            dt = d[19:0];
            if (op == rbi_pkg::OP_STEP) begin
                if (phys_en && sim_en) begin
                    if (rk4) begin
                        h2 = dt >> 1;
                        accel(vel, a);
                        stage_eval(vel, h2, a, bdx, bdv);
                        stage_eval(vel, h2, bdv, cdx, cdv);
                        stage_eval(vel, dt, cdv, ddx, ddv);
                        for (int i = 0; i < 3; i++) begin
                            sx = vel[i] + 2 * (bdx[i] + cdx[i]) + ddx[i];
                            sv = a[i] + 2 * (bdv[i] + cdv[i]) + ddv[i];
                            pos[i] = sat(pos[i] + fmul(div6_floor(sx), dt));
                            vel[i] = sat(vel[i] + fmul(div6_floor(sv), dt));
                        end
                    end else begin
                        accel(vel, a);
                        for (int i = 0; i < 3; i++) begin
                            vel[i] = sat(vel[i] + fmul(a[i], dt));
                            pos[i] = sat(pos[i] + fmul(vel[i], dt));
                        end
                    end
                end
            end else if (sim_en) begin
                mag2 = 0;
                for (int i = 0; i < 3; i++) begin
                    vel[i] = sat(vel[i] + longint'($signed(d[20+32*i +: 32])));
                    m[i] = vel[i] < 0 ? -vel[i] : vel[i];
                    mag2 += m[i] * m[i];
                end
                lim2 = lim * lim;
                if (lim_en && mag2 > lim2) begin
                    mag = isqrt(mag2);
                    if (mag == 0) mag = 1;
                    for (int i = 0; i < 3; i++) begin
                        sx = longint'((m[i] * lim) / mag);
                        vel[i] = vel[i] < 0 ? -sx : sx;
                    end
                end
            end
            for (int i = 0; i < 3; i++) begin
                st[32*i +: 32] = pos[i][31:0];
                st[96+32*i +: 32] = vel[i][31:0];
            end
            pending_states.push_back(st);
        endfunction

        // compare a result transfer with the oldest expected state
        function void check_state(logic [191:0] got);
            logic [191:0] want;
            if (pending_states.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending_states.pop_front();
            for (int f = 0; f < 6; f++) begin
                if (got[32*f +: 32] !== want[32*f +: 32]) begin
                    $display("%0t: field %0d expected %h actual %h", $time, f,
                             want[32*f +: 32], got[32*f +: 32]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic         aclk, aresetn;
    logic         s_tvalid, s_tready;
    logic [119:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid, m_tready;
    logic [191:0] m_tdata;
    logic         cfg_valid, cfg_ready;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    body_scoreboard sb;
    int  send_idle_pct, recv_stall_pct;
    longint cycles;

    rigid_body_rk4_integrator_core DUT (.*);

    // clock
    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    // cycle limit
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > 3000000) begin
                $display("tb_rigid_body_rk4_integrator_core: FAIL");
                $finish;
            end
        end
    end

    // result side: sample at rising edge, stall at the falling edge
    initial begin
        m_tready = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_state(m_tdata);
            @(negedge aclk);
            m_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // register write once no item is in flight
    task automatic write_cfg(logic [2:0] idx, logic [31:0] d);
        while (sb.pending_states.size() != 0) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1; cfg_index = idx; cfg_data = d;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, d);
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    task automatic send_item(logic op, logic [119:0] d);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_tvalid = 1; s_tuser = op; s_tdata = d;
        do @(posedge aclk); while (!s_tready);
        sb.note_item(op, d);
        @(negedge aclk);
        s_tvalid = 0;
    endtask

    task automatic drain();
        while (sb.pending_states.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [31:0] rnd_q(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
            default: return 32'($signed($urandom_range(0, 200 << 16)) - (100 << 16));
        endcase
    endfunction

    function automatic logic [119:0] rnd_item(bit big);
        logic [119:0] d;
        int mode;
        mode = big ? 0 : $urandom_range(1, 2);
        d[19:0] = big ? 20'($urandom()) : 20'($urandom_range(0, 1 << 14));
        d[51:20] = rnd_q(mode);
        d[83:52] = rnd_q(mode);
        d[115:84] = rnd_q(mode);
        d[119:116] = 0;
        return d;
    endfunction

    task automatic random_phase(int n, int idle, int stall);
        send_idle_pct = idle; recv_stall_pct = stall;
        for (int k = 0; k < n; k++)
            send_item(1'($urandom_range(1)), rnd_item($urandom_range(9) == 0));
        drain();
    endtask

    initial begin
        sb = new();
        send_idle_pct = 0; recv_stall_pct = 0;
        aresetn = 0; s_tvalid = 0; s_tdata = 0; s_tuser = 0;
        cfg_valid = 0; cfg_index = 0; cfg_data = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed: extremes, both methods, clamp, held state
        send_item(rbi_pkg::OP_STEP, {32'h0, 32'h0, 32'h0, 20'hfffff});
        send_item(rbi_pkg::OP_IMPULSE, {32'h7fffffff, 32'h80000000, 32'h7fffffff, 20'h0});
        send_item(rbi_pkg::OP_IMPULSE, {32'h80000000, 32'h7fffffff, 32'h80000000, 20'hfffff});
        write_cfg(rbi_pkg::CFG_GRAVITY_ACCEL, 32'h0009_cccd);
        write_cfg(rbi_pkg::CFG_DRAG_COEF, 32'h7fffffff);
        send_item(rbi_pkg::OP_STEP, {96'h0, 20'hfffff});
        send_item(rbi_pkg::OP_STEP, {96'h0, 20'h00001});
        write_cfg(rbi_pkg::CFG_USE_RK4, 32'h1);
        send_item(rbi_pkg::OP_STEP, {96'h0, 20'hfffff});
        send_item(rbi_pkg::OP_STEP, {96'h0, 20'h00000});
        write_cfg(rbi_pkg::CFG_DRAG_COEF, 32'h0000_8000);
        send_item(rbi_pkg::OP_STEP, {96'h0, 20'h01000});
        write_cfg(rbi_pkg::CFG_GRAVITY_ACCEL, 32'h80000000);
        send_item(rbi_pkg::OP_STEP, {96'h0, 20'h10000});
        write_cfg(rbi_pkg::CFG_SPEED_LIMIT, 32'h0);
        send_item(rbi_pkg::OP_IMPULSE, {32'h1, 32'h0, 32'hffffffff, 20'h0});
        write_cfg(rbi_pkg::CFG_SPEED_LIMIT, 32'hffffffff);
        send_item(rbi_pkg::OP_IMPULSE, {32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 20'h0});
        write_cfg(rbi_pkg::CFG_LIMIT_ENABLED, 32'h0);
        send_item(rbi_pkg::OP_IMPULSE, {32'h80000000, 32'h12345678, 32'h0, 20'h0});
        write_cfg(rbi_pkg::CFG_PHYSICS_ENABLED, 32'h0);
        send_item(rbi_pkg::OP_STEP, {96'h0, 20'h10000});
        send_item(rbi_pkg::OP_IMPULSE, {32'h00010000, 32'h0, 32'h0, 20'h0});
        write_cfg(rbi_pkg::CFG_SIMULATED, 32'h0);
        write_cfg(rbi_pkg::CFG_PHYSICS_ENABLED, 32'h1);
        send_item(rbi_pkg::OP_STEP, {96'h0, 20'h10000});
        send_item(rbi_pkg::OP_IMPULSE, {32'h00010000, 32'h0, 32'h0, 20'h0});
        drain();

        // random phases over several settings
        write_cfg(rbi_pkg::CFG_SIMULATED, 32'h1);
        write_cfg(rbi_pkg::CFG_LIMIT_ENABLED, 32'h1);
        write_cfg(rbi_pkg::CFG_SPEED_LIMIT, 32'd163840000);
        write_cfg(rbi_pkg::CFG_USE_RK4, 32'h0);
        write_cfg(rbi_pkg::CFG_DRAG_COEF, 32'h0000_1000);
        write_cfg(rbi_pkg::CFG_GRAVITY_ACCEL, 32'h0009_cccd);
        random_phase(190, 0, 0);
        write_cfg(rbi_pkg::CFG_USE_RK4, 32'h1);
        write_cfg(rbi_pkg::CFG_SPEED_LIMIT, 32'd50 << 16);
        random_phase(190, 77, 0);
        write_cfg(rbi_pkg::CFG_DRAG_COEF, $urandom());
        write_cfg(rbi_pkg::CFG_GRAVITY_ACCEL, $urandom());
        write_cfg(rbi_pkg::CFG_SPEED_LIMIT, 32'h7fffffff);
        random_phase(190, 0, 77);
        write_cfg(rbi_pkg::CFG_USE_RK4, 32'h0);
        write_cfg(rbi_pkg::CFG_SPEED_LIMIT, 32'd3 << 16);
        write_cfg(rbi_pkg::CFG_PHYSICS_ENABLED, 32'($urandom_range(1)));
        random_phase(180, 28, 28);

        if (sb.errors == 0 && sb.pending_states.size() == 0) begin
            $display("tb_rigid_body_rk4_integrator_core: PASS");
        end else begin
            $display("tb_rigid_body_rk4_integrator_core: FAIL");
        end
        $finish;
    end

endmodule
